### hw/rtl/pcls_pkg.sv
// Shared types and constants for the PID controller with clamp and smoothing.
`default_nettype none

package pcls_pkg;

   localparam int SAMPLE_W = 16;             // error and drive, signed Q8.8
   localparam int GAIN_W   = 16;             // unsigned Q4.12 gains
   localparam int SUM_W    = 32;             // integral accumulator
   localparam int WEIGHT_W = 17;             // smoothing weight, Q1.16
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int MUL_A_W  = 17;             // unsigned multiplier operand
   localparam int MUL_B_W  = 33;             // signed multiplier operand
   localparam int PROD_W   = MUL_A_W + 1 + MUL_B_W;
   localparam int ROUND_SHIFT = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_LIMIT_EN  = 3'd3,
      CSR_LIMIT_LO  = 3'd4,
      CSR_LIMIT_HI  = 3'd5,
      CSR_SMOOTH_EN = 3'd6,
      CSR_SMOOTH_W  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_PROP   = 2'd0,
      MUL_DERIV  = 2'd1,
      MUL_INTEG  = 2'd2,
      MUL_SMOOTH = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;       // latch a new item, update error state
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        acc_add;
      logic        round_en;
      logic        limit_en;
      logic        blend_en;
      logic        out_load;   // move drive into the result register
   } dp_cmd_type;

   typedef struct packed {
      logic smooth_enable;
   } dp_status_type;

endpackage

`default_nettype wire

### hw/rtl/pcls_channels.sv
// Valid/ready channel interfaces for error items and drive items.
`default_nettype none

interface pcls_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcls_pkg::SAMPLE_W-1:0] error_sample;

   modport source (output valid, output error_sample, input ready);
   modport sink   (input valid, input error_sample, output ready);
endinterface

interface pcls_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pcls_pkg::SAMPLE_W-1:0] drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

### hw/rtl/pid_controller_limit_smooth_unit.sv
// Top level of the PID controller with output clamp and smoothing.
//
// req_chan carries one signed Q8.8 error_sample per item; rsp_chan returns
// one signed Q8.8 drive per item, in order. Both use valid/ready and an item
// moves on a clock edge where both are high.
// csr_* writes one control register per cycle with csr_wr_en high; write it
// only while no item is in flight.
// An item accepted in idle passes the P, D and I products, accumulate, round
// and clamp, then with smoothing the blend product and blend, before its drive
// is loaded. One shared 18x33 multiplier is used for the three gain
// products and the blend, so items are taken one at a time.
// The result sits in an output register; the next item is accepted and
// worked on while it waits, and the sequencer holds in its last step until
// the receiver takes the previous drive.
// Synchronous reset clears the integral, previous error and previous drive,
// sets gains to zero, limits to full range, both enables off and the
// smoothing weight to one.
`default_nettype none

module pid_controller_limit_smooth_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pcls_req_if.sink                               req_chan,
   pcls_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [pcls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pcls_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import pcls_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   pcls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcls_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .error_sample (req_chan.error_sample),
      .cmd          (cmd),
      .status       (status),
      .drive        (rsp_chan.drive)
   );

endmodule

`default_nettype wire

### hw/rtl/pcls_ctrl.sv
// Sequencer for the PID datapath and the result valid flag.
`default_nettype none

module pcls_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire pcls_pkg::dp_status_type status,
   output pcls_pkg::dp_cmd_type         cmd
);
   import pcls_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_MUL_P  = 10'b00_0000_0010,
      ST_MUL_D  = 10'b00_0000_0100,
      ST_MUL_I  = 10'b00_0000_1000,
      ST_ACC_I  = 10'b00_0001_0000,
      ST_ROUND  = 10'b00_0010_0000,
      ST_LIMIT  = 10'b00_0100_0000,
      ST_MUL_S  = 10'b00_1000_0000,
      ST_BLEND  = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_sel = MUL_PROP;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_PROP;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = MUL_DERIV;
            cmd.acc_load = 1'b1;
            state_in     = ST_MUL_I;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_INTEG;
            cmd.acc_add = 1'b1;
            state_in    = ST_ACC_I;
         end
         ST_ACC_I: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit_en = 1'b1;
            state_in     = status.smooth_enable ? ST_MUL_S : ST_FINISH;
         end
         ST_MUL_S: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SMOOTH;
            state_in    = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.blend_en = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/pcls_datapath.sv
// PID datapath: control registers, error state, shared multiplier, round, clamp, blend.
`default_nettype none

module pcls_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_wr_en,
   input  wire logic [pcls_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [pcls_pkg::CSR_DATA_W-1:0]        csr_wr_data,
   input  wire logic signed [pcls_pkg::SAMPLE_W-1:0]   error_sample,
   input  wire pcls_pkg::dp_cmd_type                   cmd,
   output pcls_pkg::dp_status_type                     status,
   output logic signed [pcls_pkg::SAMPLE_W-1:0]        drive
);
   import pcls_pkg::*;

   localparam int SHIFTED_W = PROD_W - ROUND_SHIFT;

   // control registers
   logic [GAIN_W-1:0]          gain_p_ff, gain_i_ff, gain_d_ff;
   logic                       limit_en_ff, smooth_en_ff;
   logic signed [SAMPLE_W-1:0] limit_lo_ff, limit_hi_ff;
   logic [WEIGHT_W-1:0]        weight_ff;

   // loop state
   logic signed [SAMPLE_W-1:0] last_error_ff;
   logic signed [SUM_W-1:0]    error_sum_ff, error_sum_in;
   logic signed [SAMPLE_W-1:0] last_drive_ff;

   // per-item working registers
   logic signed [SAMPLE_W-1:0] e_ff;
   logic signed [SAMPLE_W:0]   d_ff, d_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   acc_ff;
   logic signed [SAMPLE_W-1:0] work_ff, work_in;
   logic signed [SAMPLE_W-1:0] drive_ff;

   logic signed [SUM_W:0]      sum_wide;
   logic [MUL_A_W-1:0]         mul_a;
   logic signed [MUL_A_W:0]    mul_a_s;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic [WEIGHT_W-1:0]        weight_eff;
   logic signed [SAMPLE_W:0]   drive_delta;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [SHIFTED_W-1:0] shifted;
   logic signed [SAMPLE_W-1:0] rounded_sat;
   logic signed [SAMPLE_W-1:0] upper_cut, clamped;
   logic signed [PROD_W-1:0]   mix;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         limit_en_ff  <= 1'b0;
         limit_lo_ff  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
         limit_hi_ff  <= {1'b0, {(SAMPLE_W-1){1'b1}}};
         smooth_en_ff <= 1'b0;
         weight_ff    <= {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:    gain_p_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_I:    gain_i_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_D:    gain_d_ff    <= csr_wr_data[GAIN_W-1:0];
            CSR_LIMIT_EN:  limit_en_ff  <= csr_wr_data[0];
            CSR_LIMIT_LO:  limit_lo_ff  <= csr_wr_data[SAMPLE_W-1:0];
            CSR_LIMIT_HI:  limit_hi_ff  <= csr_wr_data[SAMPLE_W-1:0];
            CSR_SMOOTH_EN: smooth_en_ff <= csr_wr_data[0];
            CSR_SMOOTH_W:  weight_ff    <= csr_wr_data[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign status.smooth_enable = smooth_en_ff;

   // difference and saturating integral on item entry
   assign d_in     = (SAMPLE_W+1)'(error_sample) - (SAMPLE_W+1)'(last_error_ff);
   assign sum_wide = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(error_sample);

   always_comb begin
      error_sum_in = sum_wide[SUM_W-1:0];
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         error_sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                        : {1'b0, {(SUM_W-1){1'b1}}};
      end
   end

   // weights above one act as one
   assign weight_eff  = (weight_ff[WEIGHT_W-1] && (|weight_ff[WEIGHT_W-2:0]))
                        ? {1'b1, {(WEIGHT_W-1){1'b0}}} : weight_ff;
   assign drive_delta = (SAMPLE_W+1)'(work_ff) - (SAMPLE_W+1)'(last_drive_ff);

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_PROP: begin
            mul_a = MUL_A_W'(gain_p_ff);
            mul_b = MUL_B_W'(e_ff);
         end
         MUL_DERIV: begin
            mul_a = MUL_A_W'(gain_d_ff);
            mul_b = MUL_B_W'(d_ff);
         end
         MUL_INTEG: begin
            mul_a = MUL_A_W'(gain_i_ff);
            mul_b = MUL_B_W'(error_sum_ff);
         end
         MUL_SMOOTH: begin
            mul_a = weight_eff;
            mul_b = MUL_B_W'(drive_delta);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_a_s = {1'b0, mul_a};
   assign prod_in = mul_a_s * mul_b;

   // negate, round half up, saturate to 16 bits
   assign rounded = -acc_ff + PROD_W'(1 << (ROUND_SHIFT - 1));
   assign shifted = rounded[PROD_W-1:ROUND_SHIFT];

   always_comb begin
      rounded_sat = shifted[SAMPLE_W-1:0];
      if (shifted[SHIFTED_W-1:SAMPLE_W-1] != {(SHIFTED_W-SAMPLE_W+1){shifted[SHIFTED_W-1]}})
      begin
         rounded_sat = shifted[SHIFTED_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                           : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   // upper limit first, then lower
   assign upper_cut = (work_ff > limit_hi_ff) ? limit_hi_ff : work_ff;
   assign clamped   = (upper_cut < limit_lo_ff) ? limit_lo_ff : upper_cut;

   // last*1.0 + w*(drive - last) + half, floor to Q8.8; stays between both inputs
   assign mix = (PROD_W'(last_drive_ff) <<< 16) + prod_ff + PROD_W'(32768);

   always_comb begin
      work_in = work_ff;
      if (cmd.round_en) begin
         work_in = rounded_sat;
      end else if (cmd.limit_en && limit_en_ff) begin
         work_in = clamped;
      end else if (cmd.blend_en) begin
         work_in = mix[SAMPLE_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         last_drive_ff <= '0;
      end else begin
         if (cmd.load) begin
            last_error_ff <= error_sample;
            error_sum_ff  <= error_sum_in;
         end
         if (cmd.out_load) begin
            last_drive_ff <= work_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         e_ff <= error_sample;
         d_ff <= d_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      work_ff <= work_in;
      if (cmd.out_load) begin
         drive_ff <= work_ff;
      end
   end

   assign drive = drive_ff;

endmodule

`default_nettype wire

### sim/pcls_drive_check.sv
// Predicts the drive of each accepted error item and checks the returned drive items.
`timescale 1ns / 100ps

module pcls_drive_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic signed [pcls_pkg::SAMPLE_W-1:0] req_error_sample,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [pcls_pkg::SAMPLE_W-1:0] rsp_drive,
   input  logic                                 csr_wr_en,
   input  logic [pcls_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcls_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output int unsigned                          mismatches,
   output int unsigned                          pending
);
   import pcls_pkg::*;

   localparam longint WEIGHT_ONE = 65536;

   // shadow copy of the control registers
   logic [GAIN_W-1:0]          gain_p, gain_i, gain_d;
   logic                       limit_on, smooth_on;
   logic signed [SAMPLE_W-1:0] lim_lo, lim_hi;
   logic [WEIGHT_W-1:0]        weight;

   // loop state
   logic signed [SAMPLE_W-1:0] prev_error, prev_drive;
   logic signed [SUM_W-1:0]    integral;

   logic signed [SAMPLE_W-1:0] drive_expected [$];

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(input longint v);
      if (v > 32767)
         return 16'sh7fff;
      if (v < -32768)
         return 16'sh8000;
      return v[SAMPLE_W-1:0];
   endfunction

   always @(posedge clock) begin : track
      logic signed [SAMPLE_W-1:0] sample, drv, want;
      longint sum_next, acc, w, mix;
      if (reset) begin
         gain_p     = '0;
         gain_i     = '0;
         gain_d     = '0;
         limit_on   = 1'b0;
         lim_lo     = 16'sh8000;
         lim_hi     = 16'sh7fff;
         smooth_on  = 1'b0;
         weight     = 17'd65536;
         prev_error = '0;
         prev_drive = '0;
         integral   = '0;
         drive_expected.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (drive_expected.size() == 0) begin
               $display("%0t: unexpected drive %0d, none expected", $time, rsp_drive);
               mismatches++;
            end else begin
               want = drive_expected.pop_front();
               if (rsp_drive !== want) begin
                  $display("%0t: drive mismatch: expected %0d, actual %0d",
                           $time, want, rsp_drive);
                  mismatches++;
               end
            end
         end

         if (req_valid && req_ready) begin
            sample   = req_error_sample;
            sum_next = longint'(integral) + longint'(sample);
            if (sum_next > 64'sd2147483647)
               sum_next = 64'sd2147483647;
            if (sum_next < -64'sd2147483648)
               sum_next = -64'sd2147483648;
            acc = longint'(gain_p) * longint'(sample)
                + longint'(gain_d) * (longint'(sample) - longint'(prev_error))
                + longint'(gain_i) * sum_next;
            integral   = sum_next[SUM_W-1:0];
            prev_error = sample;

            acc = -acc;
            drv = sat_sample((acc + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);

            // upper bound first, so crossed limits leave the lower one
            if (limit_on) begin
               if (drv > lim_hi)
                  drv = lim_hi;
               if (drv < lim_lo)
                  drv = lim_lo;
            end

            if (smooth_on) begin
               w   = (weight > 17'd65536) ? WEIGHT_ONE : longint'(weight);
               mix = w * longint'(drv) + (WEIGHT_ONE - w) * longint'(prev_drive) + 32768;
               drv = sat_sample(mix >>> 16);
            end

            prev_drive = drv;
            drive_expected.push_back(drv);
         end

         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_GAIN_P:    gain_p    = csr_wr_data[GAIN_W-1:0];
               CSR_GAIN_I:    gain_i    = csr_wr_data[GAIN_W-1:0];
               CSR_GAIN_D:    gain_d    = csr_wr_data[GAIN_W-1:0];
               CSR_LIMIT_EN:  limit_on  = csr_wr_data[0];
               CSR_LIMIT_LO:  lim_lo    = csr_wr_data[SAMPLE_W-1:0];
               CSR_LIMIT_HI:  lim_hi    = csr_wr_data[SAMPLE_W-1:0];
               CSR_SMOOTH_EN: smooth_on = csr_wr_data[0];
               CSR_SMOOTH_W:  weight    = csr_wr_data[WEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
      pending = drive_expected.size();
   end

endmodule

### sim/pid_controller_limit_smooth_unit_test.sv
// Stimulus, clock, reset and verdict for the PID controller with clamp and smoothing.
`timescale 1ns / 100ps

module pid_controller_limit_smooth_unit_test;
   import pcls_pkg::*;

   localparam int RANDOM_ITEMS  = 1800;
   localparam int SETTLE_CYCLES = 16;     // a bit over the smoothed latency
   localparam int STALL_LIMIT   = 2000;   // cycles with no item moving on either side
   localparam int SAT_ITEMS     = 64;

   typedef struct {
      logic [GAIN_W-1:0]          gain_p, gain_i, gain_d;
      logic                       limit_on;
      logic signed [SAMPLE_W-1:0] lower, upper;
      logic                       smooth_on;
      logic [WEIGHT_W-1:0]        weight;
   } tuning_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  steady;
   int unsigned           mismatches, pending, quiet_cycles;

   pcls_req_if req_chan ();
   pcls_rsp_if rsp_chan ();

   pid_controller_limit_smooth_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   pcls_drive_check i_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_error_sample (req_chan.error_sample),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_drive        (rsp_chan.drive),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic tuning_type make_tuning(input int kp, input int ki, input int kd,
                                              input bit lim, input int lo, input int hi,
                                              input bit sm, input int w);
      tuning_type t;
      t.gain_p    = kp[GAIN_W-1:0];
      t.gain_i    = ki[GAIN_W-1:0];
      t.gain_d    = kd[GAIN_W-1:0];
      t.limit_on  = lim;
      t.lower     = lo[SAMPLE_W-1:0];
      t.upper     = hi[SAMPLE_W-1:0];
      t.smooth_on = sm;
      t.weight    = w[WEIGHT_W-1:0];
      return t;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain(input bit integ);
      case ($urandom_range(3))
         0: return '0;
         1: return integ ? GAIN_W'($urandom_range(1, 16)) : 16'hffff;
         2: return integ ? GAIN_W'($urandom_range(0, 255)) : GAIN_W'($urandom_range(0, 8191));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic tuning_type random_tuning();
      tuning_type t;
      logic signed [SAMPLE_W-1:0] a, b;
      t.gain_p   = pick_gain(1'b0);
      t.gain_i   = pick_gain(1'b1);
      t.gain_d   = pick_gain(1'b0);
      t.limit_on = 1'($urandom_range(1));
      a = SAMPLE_W'($urandom);
      b = SAMPLE_W'($urandom);
      case ($urandom_range(7))
         0: begin
            t.lower = 16'sh8000;
            t.upper = 16'sh7fff;
         end
         1: begin                       // crossed limits
            t.lower = (a > b) ? a : b;
            t.upper = (a > b) ? b : a;
         end
         default: begin
            t.lower = (a > b) ? b : a;
            t.upper = (a > b) ? a : b;
         end
      endcase
      t.smooth_on = 1'($urandom_range(1));
      case ($urandom_range(3))
         0: t.weight = '0;
         1: t.weight = 17'd65536;
         2: t.weight = WEIGHT_W'($urandom_range(65537, 131071));
         default: t.weight = WEIGHT_W'($urandom_range(1, 65535));
      endcase
      return t;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_error();
      case ($urandom_range(7))
         0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         1, 2: return SAMPLE_W'(int'($urandom_range(1023)) - 512);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // unused upper data bits carry noise; the block must ignore them
   function automatic logic [CSR_DATA_W-1:0] register_word(input tuning_type t,
                                                           input csr_index_type r);
      logic [CSR_DATA_W-1:0] w;
      w = CSR_DATA_W'($urandom);
      case (r)
         CSR_GAIN_P:    w[GAIN_W-1:0]   = t.gain_p;
         CSR_GAIN_I:    w[GAIN_W-1:0]   = t.gain_i;
         CSR_GAIN_D:    w[GAIN_W-1:0]   = t.gain_d;
         CSR_LIMIT_EN:  w[0]            = t.limit_on;
         CSR_LIMIT_LO:  w[SAMPLE_W-1:0] = t.lower;
         CSR_LIMIT_HI:  w[SAMPLE_W-1:0] = t.upper;
         CSR_SMOOTH_EN: w[0]            = t.smooth_on;
         CSR_SMOOTH_W:  w               = t.weight;
         default: ;
      endcase
      return w;
   endfunction

   // called at a falling edge; returns at a falling edge
   task automatic apply_tuning(input tuning_type t);
      req_chan.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      for (int i = CSR_GAIN_P; i <= CSR_SMOOTH_W; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= CSR_IDX_W'(i);
         csr_wr_data <= register_word(t, csr_index_type'(i));
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_error(input logic signed [SAMPLE_W-1:0] e);
      while (!steady && $urandom_range(99) < 24) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.error_sample <= e;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int sent, n;
      reset                 = 1'b1;
      steady                = 1'b0;
      req_chan.valid        = 1'b0;
      req_chan.error_sample = '0;
      rsp_chan.ready        = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wr_data           = '0;
      quiet_cycles          = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // unity proportional gain, field extremes and alternating bits
      apply_tuning(make_tuning(4096, 0, 0, 0, -32768, 32767, 0, 65536));
      send_error(16'sh0000);
      send_error(16'sh7fff);
      send_error(16'sh8000);
      send_error(16'sh0001);
      send_error(16'shffff);
      send_error(16'sh5555);
      send_error(16'shaaaa);
      // full gains overflow the drive, then the clamp holds it
      apply_tuning(make_tuning(65535, 65535, 65535, 1, -256, 256, 0, 65536));
      send_error(16'sh7fff);
      send_error(16'sh8000);
      send_error(16'sh8000);
      send_error(16'sd100);
      // crossed limits give the lower limit
      apply_tuning(make_tuning(4096, 0, 0, 1, 1000, -1000, 0, 65536));
      send_error(16'sd5000);
      send_error(-16'sd5000);
      send_error(16'sd0);
      // weight above one
      apply_tuning(make_tuning(4096, 0, 2048, 0, -32768, 32767, 1, 131071));
      send_error(16'sd2000);
      send_error(-16'sd2000);
      // weight zero holds the previous drive
      apply_tuning(make_tuning(4096, 0, 0, 0, -32768, 32767, 1, 0));
      send_error(16'sd3000);
      send_error(-16'sd3000);
      // half weight with limits at full range
      apply_tuning(make_tuning(8192, 16, 4096, 1, -32768, 32767, 1, 32768));
      send_error(16'sh7fff);
      send_error(16'sh8000);
      send_error(16'sh0001);
      send_error(16'shffff);
      apply_tuning(make_tuning(0, 0, 0, 0, -32768, 32767, 1, 1));
      send_error(16'shffff);
      send_error(16'sd12345);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         n      = $urandom_range(20, 120);
         steady = (sent >= 700 && sent < 1050);
         apply_tuning(random_tuning());
         repeat (n) send_error(random_error());
         sent += n;
      end

      // run the integral negative with full-scale negative errors, then
      // send full-scale positive errors and random errors
      steady = 1'b1;
      apply_tuning(make_tuning(65535, 1, 0, 0, -32768, 32767, 0, 65536));
      repeat (SAT_ITEMS) send_error(16'sh8000);
      repeat (8) send_error(16'sh7fff);
      repeat (8) send_error(random_error());
      steady = 1'b0;

      req_chan.valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
